// File: rtl/core/jacobi_stencil_sweep_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Jacobi stencil sweep
// Shared shorthand for concurrent checks clocked on clk, reset on arst_n.
// ----------------------------------------------------------------------------
`ifndef JACOBI_STENCIL_SWEEP_DEFINES_SVH
`define JACOBI_STENCIL_SWEEP_DEFINES_SVH

// same-cycle implication
`define JSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/jss_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Field widths, register indexes, reset values and shared helpers.
// ----------------------------------------------------------------------------
package jss_pkg;

	// field widths
	localparam int VAL_W     = 23;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 10;
	localparam int ROWS_W    = 13;
	localparam int COLS_W    = 11;
	localparam int CFG_IDX_W = 2;

	// default geometry limits
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

	// reset values
	localparam int GRID_RESET = 3;
	localparam int TOL_RESET  = 66;
	localparam int DIM_MIN    = 3;

	// position of an interior point travelling down the pipe
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} point_tag_t;

	// limit a grid dimension to DIM_MIN..hi
	function automatic logic [ROWS_W-1:0] clamp_dim(logic [ROWS_W-1:0] v, int hi);
		logic [ROWS_W-1:0] res;
		res = v;
		if (v < ROWS_W'(DIM_MIN))
			res = ROWS_W'(DIM_MIN);
		else if (int'(v) > hi)
			res = ROWS_W'(hi);
		return res;
	endfunction

endpackage

// File: rtl/core/jss_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module jss_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/jacobi_stencil_sweep.sv
// ----------------------------------------------------------------------------
// Jacobi five-point stencil sweep
// Streams an old grid in raster order and emits Jacobi updates for every
// interior point, with the running maximum change and a convergence flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / old_value): one grid value per item,
//   raster order, rows of grid_cols values. Output channel (out_valid /
//   out_stall / point_row ...): one item per interior point, none for points
//   in the first two rows or columns of the stream.
//   Throughput: one item per cycle while in_stall is low. Each item costs
//   one read and one write of the line RAM (one entry per column holding the
//   two previous rows). A result passes stage 1, stage 2, stage 3 and the
//   output register before it is shown.
//   The last interior point carries sweep_done and converged; the next item
//   starts a new sweep. Writing grid_rows or grid_cols restarts the sweep.
//   Reset: registers return to defaults (3 x 3 grid, tolerance 66); the line
//   RAM is not cleared and needs no clearing pass, items are taken at once.
//   Stall: the output register holds its item; up to three more items with a
//   result are taken into the pipe (items with none pass freely) before
//   in_stall rises.
// ----------------------------------------------------------------------------
module jacobi_stencil_sweep #(
	parameter int MAX_COLS = jss_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = jss_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [jss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jss_pkg::VAL_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [jss_pkg::VAL_W-1:0]      old_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [jss_pkg::ROW_W-1:0]      point_row,
	output logic [jss_pkg::COL_W-1:0]      point_col,
	output logic [jss_pkg::VAL_W-1:0]      new_value,
	output logic [jss_pkg::VAL_W-1:0]      max_change,
	output logic                           sweep_done,
	output logic                           converged
);
	import jss_pkg::*;

	localparam int CAW = $clog2(MAX_COLS);

	// configuration
	logic [ROWS_W-1:0] rows_lim_q;
	logic [COLS_W-1:0] cols_lim_q;
	logic [VAL_W-1:0]  tol_q;
	logic              geom_wr;

	// input position
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             acc, col_end, row_end, last_in, res_in;

	// stage 1: RAM data available
	logic             s1_v;
	logic [VAL_W-1:0] v_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             last_s1, res_s1;
	logic [2*VAL_W-1:0] rd;
	logic [VAL_W-1:0] rd_up, rd_east;
	logic [VAL_W+1:0] sum;

	// neighbour taps from the previous item (e2_q from the one before it)
	logic [VAL_W-1:0] up_q, e1_q, e2_q, vp_q;

	// stage 2: average ready
	logic             s2_v;
	logic [VAL_W-1:0] avg_s2, centre_s2;
	point_tag_t       tag_s2;
	logic [VAL_W-1:0] change;

	// stage 3: change ready
	logic             s3_v;
	logic [VAL_W-1:0] avg_s3, change_s3;
	point_tag_t       tag_s3;
	logic [VAL_W-1:0] rm_q, rm_next;
	logic             conv;

	// output register
	logic             out_valid_q;
	point_tag_t       tag_q;
	logic [VAL_W-1:0] new_value_q, max_change_q;
	logic             converged_q;

	// flow control
	logic out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free;

	assign geom_wr = cfg_we && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS);

	// register writes, geometry stored already limited
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_lim_q <= ROWS_W'(GRID_RESET);
			cols_lim_q <= COLS_W'(GRID_RESET);
			tol_q      <= VAL_W'(TOL_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_ROWS: rows_lim_q <= clamp_dim(cfg_data[ROWS_W-1:0], MAX_ROWS);
				REG_GRID_COLS: cols_lim_q <=
					COLS_W'(clamp_dim({2'b00, cfg_data[COLS_W-1:0]}, MAX_COLS));
				REG_TOLERANCE: tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		s3_move  = s3_v && out_free;
		s3_free  = !s3_v || out_free;
		s2_move  = s2_v && s3_free;
		s2_free  = !s2_v || s3_free;
		s1_move  = s1_v && (!res_s1 || s2_free);
		s1_free  = !s1_v || !res_s1 || s2_free;
	end

	assign in_stall = !s1_free;
	assign acc      = in_valid && s1_free;

	// position decode of the incoming item
	assign col_end = ({1'b0, col_q} + COLS_W'(1)) >= cols_lim_q;
	assign row_end = ({1'b0, row_q} + ROWS_W'(1)) >= rows_lim_q;
	assign last_in = row_end && col_end;
	assign res_in  = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (geom_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (last_in) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_end) begin
				row_q <= row_q + ROW_W'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line RAM: entry per column holds {row r-2, row r-1}
	jss_ram #(
		.WIDTH(2*VAL_W),
		.DEPTH(MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_move),
		.waddr (CAW'(col_s1)),
		.wdata ({rd_east, v_s1}),
		.re    (acc),
		.raddr (CAW'(col_q)),
		.rdata (rd)
	);

	assign rd_up   = rd[2*VAL_W-1:VAL_W];
	assign rd_east = rd[VAL_W-1:0];

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (acc) begin
			s1_v <= 1'b1;
		end else if (s1_move) begin
			s1_v <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1    <= old_value;
			row_s1  <= row_q;
			col_s1  <= col_q;
			last_s1 <= last_in;
			res_s1  <= res_in;
		end
	end

	// north + south + west + east, floor of quarter
	assign sum = {2'b00, up_q} + {2'b00, vp_q} + {2'b00, e2_q} + {2'b00, rd_east};

	// taps shift as each item leaves stage 1
	always_ff @(posedge clk) begin
		if (s1_move) begin
			up_q <= rd_up;
			e1_q <= rd_east;
			e2_q <= e1_q;
			vp_q <= v_s1;
		end
	end

	// stage 2: only items with a result go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_move && res_s1) begin
			s2_v <= 1'b1;
		end else if (s2_move) begin
			s2_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && res_s1) begin
			avg_s2      <= sum[VAL_W+1:2];
			centre_s2   <= e1_q;
			tag_s2.row  <= row_s1 - ROW_W'(1);
			tag_s2.col  <= col_s1 - COL_W'(1);
			tag_s2.last <= last_s1;
		end
	end

	// absolute change against the old centre value
	assign change = (avg_s2 >= centre_s2) ? (avg_s2 - centre_s2) : (centre_s2 - avg_s2);

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (s2_move) begin
			s3_v <= 1'b1;
		end else if (s3_move) begin
			s3_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			avg_s3    <= avg_s2;
			change_s3 <= change;
			tag_s3    <= tag_s2;
		end
	end

	// running maximum and convergence test
	assign rm_next = (change_s3 > rm_q) ? change_s3 : rm_q;
	assign conv    = tag_s3.last && (rm_next < tol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rm_q <= '0;
		end else if (geom_wr) begin
			rm_q <= '0;
		end else if (s3_move) begin
			rm_q <= tag_s3.last ? '0 : rm_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_move) begin
			tag_q        <= tag_s3;
			new_value_q  <= avg_s3;
			max_change_q <= rm_next;
			converged_q  <= conv;
		end
	end

	assign out_valid  = out_valid_q;
	assign point_row  = tag_q.row;
	assign point_col  = tag_q.col;
	assign new_value  = new_value_q;
	assign max_change = max_change_q;
	assign sweep_done = tag_q.last;
	assign converged  = converged_q;

endmodule

// File: rtl/core/jss_checker.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "jacobi_stencil_sweep_defines.svh"

module jss_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [jss_pkg::ROW_W-1:0] point_row,
	input logic [jss_pkg::COL_W-1:0] point_col,
	input logic [jss_pkg::VAL_W-1:0] new_value,
	input logic [jss_pkg::VAL_W-1:0] max_change,
	input logic                      sweep_done,
	input logic                      converged
);

	// converged only ever rides on the last point of a sweep
	`JSS_ASSERT_IMP(a_conv_last, out_valid && converged, sweep_done, "converged without sweep_done")

	// results are interior points only
	`JSS_ASSERT_IMP(a_interior, out_valid, point_row != '0 && point_col != '0, "boundary point emitted")

	// input backs up only behind a held output item
	`JSS_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

	// stalled output item holds
	`JSS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(new_value) && $stable(max_change) && $stable(point_row)
		&& $stable(point_col) && $stable(sweep_done) && $stable(converged),
		"stalled output item changed")

endmodule

bind jacobi_stencil_sweep jss_checker u_jss_checker (.*);
